// ===== hw/rtl/lfid_pkg.sv =====
// Shared constants and codes for the lowest free id owner table.
package lfid_pkg;

	localparam int unsigned MAX_USERS_DEF       = 64;
	localparam int unsigned MAX_CHUNKS_DEF      = 256;
	localparam int unsigned MAX_JOIN_CHUNKS_DEF = 100;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;

	localparam opcode_t OP_JOIN    = 2'd0;
	localparam opcode_t OP_LEAVE   = 2'd1;
	localparam opcode_t OP_REQUEST = 2'd2;

	localparam kind_t KIND_ASSIGNED = 2'd0;
	localparam kind_t KIND_LEFT     = 2'd1;
	localparam kind_t KIND_OWNER    = 2'd2;
	localparam kind_t KIND_NO_OWNER = 2'd3;

	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_FULL    = 2'd1;
	localparam status_t STAT_NO_USER = 2'd2;

endpackage

// ===== hw/rtl/lowest_free_id_owner_table_top.sv =====
// Lowest free id allocator with per-chunk owner masks held in synchronous memory.
// A join item that is not last is stored; the last one takes the lowest free id, if any, then does
// one owner read-modify-write per collected chunk; leave sweeps the owner memory, one entry per cycle;
// request reads the owner entry, then gives one result per owner per cycle while out_stall is low.
// One item at a time; a new item is taken while the last result still waits at the output.
// After reset the owner memory is zeroed one entry per cycle, with in_stall high.
module lowest_free_id_owner_table_top #(
	parameter int unsigned MAX_USERS       = lfid_pkg::MAX_USERS_DEF,
	parameter int unsigned MAX_CHUNKS      = lfid_pkg::MAX_CHUNKS_DEF,
	parameter int unsigned MAX_JOIN_CHUNKS = lfid_pkg::MAX_JOIN_CHUNKS_DEF,
	localparam int unsigned UIDW = $clog2(MAX_USERS + 1),
	localparam int unsigned CIDW = $clog2(MAX_CHUNKS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  lfid_pkg::opcode_t       opcode,
	input  logic [UIDW-1:0]         user_id,
	input  logic [CIDW-1:0]         chunk_id,
	input  logic                    chunk_valid,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output lfid_pkg::kind_t         kind,
	output logic [UIDW-1:0]         result_user,
	output logic                    last_result,
	output lfid_pkg::status_t       status
);

	localparam int unsigned UIW  = $clog2(MAX_USERS);
	localparam int unsigned CW   = $clog2(MAX_CHUNKS);
	localparam int unsigned PIW  = (MAX_JOIN_CHUNKS > 1) ? $clog2(MAX_JOIN_CHUNKS) : 1;
	localparam int unsigned CNTW = $clog2(MAX_JOIN_CHUNKS + 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_EMIT  = 4'd2;
	localparam logic [3:0] ST_JEVAL = 4'd3;
	localparam logic [3:0] ST_JRDP  = 4'd4;
	localparam logic [3:0] ST_JRDO  = 4'd5;
	localparam logic [3:0] ST_JWR   = 4'd6;
	localparam logic [3:0] ST_LEAVE = 4'd7;
	localparam logic [3:0] ST_RREAD = 4'd8;
	localparam logic [3:0] ST_RLIST = 4'd9;

	function automatic logic [UIDW-1:0] enc_user(input logic [MAX_USERS-1:0] oh);
		logic [UIDW-1:0] u;
		u = '0;
		for (int i = 0; i < MAX_USERS; i++) begin
			if (oh[i]) begin
				u = u | UIDW'(i + 1);
			end
		end
		return u;
	endfunction

	// memories
	logic [MAX_USERS-1:0] own_mem [MAX_CHUNKS];
	logic [MAX_USERS-1:0] own_rd_q;
	logic [CW-1:0]        pend_mem [MAX_JOIN_CHUNKS];
	logic [CW-1:0]        pend_rd_q;

	logic                 own_re, own_we, pend_re, pend_we;
	logic [CW-1:0]        own_ra, own_wa, pend_wd;
	logic [MAX_USERS-1:0] own_wd;
	logic [PIW-1:0]       pend_ra, pend_wa;

	// control state
	logic [3:0]           state_q, state_d;
	logic [MAX_USERS-1:0] active_q, active_d;
	logic [CNTW-1:0]      cnt_q, cnt_d;
	logic [PIW-1:0]       jidx_q, jidx_d;
	logic [CIDW-1:0]      sw_q, sw_d;
	logic                 sw_s1, sw_d1;
	logic                 out_valid_q, out_valid_d;

	// datapath registers
	logic [CW-1:0]        swa_s1;
	logic [MAX_USERS-1:0] bit_q, bit_d, list_q, list_d;
	logic [CW-1:0]        rch_q;
	logic                 rok_q, rpres_q;
	lfid_pkg::kind_t      rkind_q, rkind_d;
	logic [UIDW-1:0]      ruser_q, ruser_d;
	lfid_pkg::status_t    rstat_q, rstat_d;

	lfid_pkg::kind_t      out_kind_q, out_kind_d;
	logic [UIDW-1:0]      out_user_q, out_user_d;
	logic                 out_last_q, out_last_d;
	lfid_pkg::status_t    out_stat_q, out_stat_d;
	logic                 out_load;

	// input decode
	logic                 acc, chunk_ok, uid_ok, present, join_take, out_free, sw_more;
	logic [CW-1:0]        cidx;
	logic [UIW-1:0]       uidx;
	logic [MAX_USERS-1:0] ubit, free_low, list_low, list_rest, req_word;

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign chunk_ok = (chunk_id != '0) && (chunk_id <= CIDW'(MAX_CHUNKS));
	assign cidx     = CW'(chunk_id - CIDW'(1));
	assign uid_ok   = (user_id != '0) && (user_id <= UIDW'(MAX_USERS));
	assign uidx     = UIW'(user_id - UIDW'(1));
	assign present  = uid_ok && active_q[uidx];
	assign ubit     = present ? (MAX_USERS'(1) << uidx) : '0;
	assign join_take = chunk_valid && chunk_ok && (cnt_q < CNTW'(MAX_JOIN_CHUNKS));

	// lowest clear bit of the active mask, lowest set bit of the owner list
	assign free_low  = ~active_q & (active_q + MAX_USERS'(1));
	assign list_low  = list_q & (~list_q + MAX_USERS'(1));
	assign list_rest = list_q & ~list_low;
	assign req_word  = rok_q ? own_rd_q : '0;
	assign out_free  = !out_valid_q || !out_stall;
	assign sw_more   = (sw_q != CIDW'(MAX_CHUNKS));

	// memory port control
	always_comb begin
		own_re  = 1'b0;
		own_ra  = cidx;
		own_we  = 1'b0;
		own_wa  = sw_q[CW-1:0];
		own_wd  = '0;
		pend_re = 1'b0;
		pend_ra = jidx_q;
		pend_we = 1'b0;
		pend_wa = cnt_q[PIW-1:0];
		pend_wd = cidx;
		unique case (state_q)
			ST_CLEAR: begin
				own_we = 1'b1;
			end
			ST_IDLE: begin
				own_re  = acc && (opcode == lfid_pkg::OP_REQUEST) && chunk_ok;
				pend_we = acc && (opcode == lfid_pkg::OP_JOIN) && join_take;
			end
			ST_JRDP: begin
				pend_re = 1'b1;
			end
			ST_JRDO: begin
				own_re = 1'b1;
				own_ra = pend_rd_q;
			end
			ST_JWR: begin
				own_we = 1'b1;
				own_wa = pend_rd_q;
				own_wd = own_rd_q | bit_q;
			end
			ST_LEAVE: begin
				own_re = sw_more;
				own_ra = sw_q[CW-1:0];
				own_we = sw_s1;
				own_wa = swa_s1;
				own_wd = own_rd_q & ~bit_q;
			end
			ST_RREAD: begin
				own_we = rpres_q && (req_word != '0);
				own_wa = rch_q;
				own_wd = req_word | bit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			own_mem[own_wa] <= own_wd;
		end
		if (own_re) begin
			own_rd_q <= own_mem[own_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_wa] <= pend_wd;
		end
		if (pend_re) begin
			pend_rd_q <= pend_mem[pend_ra];
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		active_d = active_q;
		cnt_d    = cnt_q;
		jidx_d   = jidx_q;
		sw_d     = sw_q;
		sw_d1    = 1'b0;
		bit_d    = bit_q;
		list_d   = list_q;
		rkind_d  = rkind_q;
		ruser_d  = ruser_q;
		rstat_d  = rstat_q;
		unique case (state_q)
			ST_CLEAR: begin
				sw_d = sw_q + CIDW'(1);
				if (sw_q == CIDW'(MAX_CHUNKS - 1)) begin
					sw_d    = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (opcode)
						lfid_pkg::OP_JOIN: begin
							if (join_take) begin
								cnt_d = cnt_q + CNTW'(1);
							end
							if (last) begin
								state_d = ST_JEVAL;
							end
						end
						lfid_pkg::OP_LEAVE: begin
							if (present) begin
								active_d = active_q & ~ubit;
								bit_d    = ubit;
								sw_d     = '0;
								state_d  = ST_LEAVE;
							end else begin
								rkind_d = lfid_pkg::KIND_LEFT;
								ruser_d = '0;
								rstat_d = lfid_pkg::STAT_NO_USER;
								state_d = ST_EMIT;
							end
						end
						lfid_pkg::OP_REQUEST: begin
							bit_d   = ubit;
							rstat_d = present ? lfid_pkg::STAT_OK : lfid_pkg::STAT_NO_USER;
							state_d = ST_RREAD;
						end
						default: begin
							// drop undefined opcode
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_JEVAL: begin
				rkind_d = lfid_pkg::KIND_ASSIGNED;
				if (free_low == '0) begin
					ruser_d = '0;
					rstat_d = lfid_pkg::STAT_FULL;
					cnt_d   = '0;
					state_d = ST_EMIT;
				end else begin
					active_d = active_q | free_low;
					bit_d    = free_low;
					ruser_d  = enc_user(free_low);
					rstat_d  = lfid_pkg::STAT_OK;
					jidx_d   = '0;
					state_d  = (cnt_q == '0) ? ST_EMIT : ST_JRDP;
				end
			end
			ST_JRDP: begin
				state_d = ST_JRDO;
			end
			ST_JRDO: begin
				state_d = ST_JWR;
			end
			ST_JWR: begin
				if (CNTW'(jidx_q) + CNTW'(1) == cnt_q) begin
					cnt_d   = '0;
					state_d = ST_EMIT;
				end else begin
					jidx_d  = jidx_q + PIW'(1);
					state_d = ST_JRDP;
				end
			end
			ST_LEAVE: begin
				sw_d1 = sw_more;
				if (sw_more) begin
					sw_d = sw_q + CIDW'(1);
				end else if (sw_s1) begin
					rkind_d = lfid_pkg::KIND_LEFT;
					ruser_d = '0;
					rstat_d = lfid_pkg::STAT_OK;
					state_d = ST_EMIT;
				end
			end
			ST_RREAD: begin
				list_d = req_word;
				if (req_word == '0) begin
					rkind_d = lfid_pkg::KIND_NO_OWNER;
					ruser_d = '0;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_RLIST;
				end
			end
			ST_RLIST: begin
				if (out_free) begin
					list_d = list_rest;
					if (list_rest == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_comb begin
		out_load   = 1'b0;
		out_kind_d = rkind_q;
		out_user_d = ruser_q;
		out_last_d = 1'b1;
		out_stat_d = rstat_q;
		if (state_q == ST_EMIT && out_free) begin
			out_load = 1'b1;
		end else if (state_q == ST_RLIST && out_free) begin
			out_load   = 1'b1;
			out_kind_d = lfid_pkg::KIND_OWNER;
			out_user_d = enc_user(list_low);
			out_last_d = (list_rest == '0);
		end
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			active_q    <= '0;
			cnt_q       <= '0;
			jidx_q      <= '0;
			sw_q        <= '0;
			sw_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			cnt_q       <= cnt_d;
			jidx_q      <= jidx_d;
			sw_q        <= sw_d;
			sw_s1       <= sw_d1;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		swa_s1  <= sw_q[CW-1:0];
		bit_q   <= bit_d;
		list_q  <= list_d;
		rkind_q <= rkind_d;
		ruser_q <= ruser_d;
		rstat_q <= rstat_d;
		if (acc) begin
			rch_q   <= cidx;
			rok_q   <= chunk_ok;
			rpres_q <= present;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_user_q <= out_user_d;
			out_last_q <= out_last_d;
			out_stat_q <= out_stat_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign result_user = out_user_q;
	assign last_result = out_last_q;
	assign status      = out_stat_q;

endmodule
